/* design/ffa_pkg.sv */
package ffa_pkg;

	// request kinds (s_tuser[0])
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// result status (m_tuser[0])
	localparam logic STAT_DONE = 1'b0;
	localparam logic STAT_FAIL = 1'b1;

	// register map, word index = paddr[2]
	localparam int   APB_AW       = 3;
	localparam logic REG_MIN_GROW = 1'b0;

	localparam int          MG_W     = 13;
	localparam logic [12:0] MG_RESET = 13'd512;

	localparam int SIZE_W  = 16;
	localparam int BADDR_W = 12;
	localparam int PAY_W   = 12;

	// byte count plus rounding always fits in this many bits
	localparam int BYTES_XW = 17;

endpackage

/* design/ffa_ram.sv */
module ffa_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/first_fit_free_list_allocator_top.sv */
// channel   | dir | beat payload                                        | handshake
// s_*       | in  | tuser[0] req_type; tdata size_bytes, block_address | tvalid/tready
// m_*       | out | tuser[0] status; tdata payload_address             | tvalid/tready
// APB       | in  | min_grow_units at 0x0                               | psel/penable
//
// One request at a time. Allocate walks the free list node by node from the
// rover; an arena growth adds an insertion walk for the grown block. Free
// walks the list node by node to the insertion point. The header
// RAM (one read or write port access per cycle) sets the walk rate.
// Reset clears control only; headers are written before use, no clearing pass.
// A finished result sits in the output register; the next request is taken
// while it waits, and a stalled m side holds the next result, and with it new requests, back.
module first_fit_free_list_allocator_top #(
	parameter int HEAP_UNITS = 4096,
	parameter int UNIT_BYTES = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // size_bytes[15:0], block_address[27:16]
	input  logic [0:0]                  s_tuser,  // req_type[0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,  // payload_address[11:0]
	output logic [0:0]                  m_tuser,  // status[0]
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ffa_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	import ffa_pkg::*;

	// HEAP_UNITS is a power of two; header indexes wrap on the low AW bits
	localparam int AW  = $clog2(HEAP_UNITS);
	localparam int SW  = AW + 2;
	localparam int EW  = AW + SW;
	localparam int BW  = AW + 1;
	localparam int LB  = $clog2(UNIT_BYTES);
	localparam int SH  = BYTES_XW + LB;
	localparam int RW  = BYTES_XW + 2;
	localparam int PW  = BYTES_XW + RW;
	localparam longint RECIP = ((longint'(1) << SH) + UNIT_BYTES - 1) / UNIT_BYTES;
	localparam int NMAX = (65535 + UNIT_BYTES - 1) / UNIT_BYTES + 1;
	localparam int NW  = $clog2(NMAX + 1);
	localparam int CW  = (SW > NW ? SW : NW) + 1;
	localparam int VW  = (NW > MG_W ? NW : MG_W);
	localparam int GW  = (BW > VW ? BW : VW) + 1;
	localparam int LIMIT = 2 * HEAP_UNITS + 8;
	localparam int TW  = $clog2(LIMIT + 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ENS     = 4'd1;
	localparam logic [3:0] S_A_ROV   = 4'd2;
	localparam logic [3:0] S_A_PREV  = 4'd3;
	localparam logic [3:0] S_A_WALK  = 4'd4;
	localparam logic [3:0] S_A_SPLIT = 4'd5;
	localparam logic [3:0] S_A_RDP   = 4'd6;
	localparam logic [3:0] S_G_RD    = 4'd7;
	localparam logic [3:0] S_G_WR    = 4'd8;
	localparam logic [3:0] S_F_RD    = 4'd9;
	localparam logic [3:0] S_F_BP    = 4'd10;
	localparam logic [3:0] S_R_START = 4'd11;
	localparam logic [3:0] S_R_WALK  = 4'd12;
	localparam logic [3:0] S_R_NX    = 4'd13;
	localparam logic [3:0] S_R_WP    = 4'd14;
	localparam logic [3:0] S_DONE    = 4'd15;

	logic [3:0]      state_q;
	logic            req_q;
	logic [NW-1:0]   n_q;
	logic [AW-1:0]   p_q, prev_q, bp_q, nx_q, sp_q, rover_q;
	logic [SW-1:0]   prev_size_q, psize_q, bsize_q;
	logic [AW-1:0]   blink_q;
	logic [TW-1:0]   steps_q, rsteps_q;
	logic            from_alloc_q;
	logic            ready_q;
	logic [BW-1:0]   brk_q;
	logic [MG_W-1:0] mg_q;
	logic [PAY_W-1:0] res_addr_q, out_addr_q;
	logic            res_fail_q, out_fail_q, out_valid_q;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [EW-1:0]   ram_wdata, ram_rdata;
	logic [AW-1:0]   rd_link;
	logic [SW-1:0]   rd_size;

	assign rd_link = ram_rdata[EW-1:SW];
	assign rd_size = ram_rdata[SW-1:0];

	ffa_ram #(
		.WIDTH(EW),
		.DEPTH(HEAP_UNITS)
	) u_hdr (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// units = ceil(bytes / UNIT_BYTES) + 1, by reciprocal multiply
	logic [BYTES_XW-1:0] bytes_rnd;
	logic [PW-1:0]       bytes_prod;
	logic [NW-1:0]       n_in;
	logic [31:0]         baddr_m1;

	assign bytes_rnd  = BYTES_XW'(s_tdata[15:0]) + BYTES_XW'(UNIT_BYTES - 1);
	assign bytes_prod = PW'(bytes_rnd) * PW'(RECIP);
	assign n_in       = NW'(bytes_prod >> SH) + NW'(1);
	assign baddr_m1   = 32'(s_tdata[27:16]) - 32'd1;

	// allocate walk
	logic          fit, exact, at_rover, walk_end, rwalk_end;
	logic [SW-1:0] split_size;
	logic [SW:0]   split_sum;
	logic [VW-1:0] nu;
	logic [GW-1:0] gsum;
	logic          gfail;
	logic [AW:0]   p_plus1, sp_plus1;

	assign fit        = CW'(rd_size) >= CW'(n_q);
	assign exact      = CW'(rd_size) == CW'(n_q);
	assign at_rover   = p_q == rover_q;
	assign walk_end   = steps_q == TW'(LIMIT);
	assign rwalk_end  = rsteps_q == TW'(LIMIT);
	assign split_size = rd_size - SW'(n_q);
	assign split_sum  = (SW+1)'(p_q) + (SW+1)'(split_size);
	assign nu         = (VW'(n_q) < VW'(mg_q)) ? VW'(mg_q) : VW'(n_q);
	assign gsum       = GW'(brk_q) + GW'(nu);
	assign gfail      = (gsum > GW'(HEAP_UNITS)) || (GW'(brk_q) >= GW'(HEAP_UNITS));
	assign p_plus1    = (AW+1)'(p_q) + (AW+1)'(1);
	assign sp_plus1   = (AW+1)'(sp_q) + (AW+1)'(1);

	// insertion walk and merges
	logic          r_stop, bmerge, pmerge;
	logic [AW-1:0] bnew_link, pnew_link;
	logic [SW-1:0] bnew_size, pnew_size;

	assign r_stop = ((bp_q > p_q) && (bp_q < rd_link)) ||
	                ((p_q >= rd_link) && ((bp_q > p_q) || (bp_q < rd_link)));
	assign bmerge    = ((SW+1)'(bp_q) + (SW+1)'(bsize_q)) == (SW+1)'(nx_q);
	assign bnew_link = bmerge ? rd_link : nx_q;
	assign bnew_size = bmerge ? bsize_q + rd_size : bsize_q;
	assign pmerge    = ((SW+1)'(p_q) + (SW+1)'(psize_q)) == (SW+1)'(bp_q);
	assign pnew_link = pmerge ? blink_q : bp_q;
	assign pnew_size = pmerge ? psize_q + bsize_q : psize_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_ENS: begin
				ram_we = 1'b1;
			end
			S_A_ROV, S_R_START, S_F_BP: begin
				ram_re    = 1'b1;
				ram_raddr = rover_q;
			end
			S_A_PREV: begin
				ram_re    = 1'b1;
				ram_raddr = rd_link;
			end
			S_A_WALK: begin
				if (fit) begin
					ram_we = 1'b1;
					if (exact) begin
						ram_waddr = prev_q;
						ram_wdata = {rd_link, prev_size_q};
					end else begin
						ram_waddr = p_q;
						ram_wdata = {rd_link, split_size};
					end
				end else if (!at_rover && !walk_end) begin
					ram_re    = 1'b1;
					ram_raddr = rd_link;
				end
			end
			S_A_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = sp_q;
				ram_wdata = {AW'(0), SW'(n_q)};
			end
			S_A_RDP: begin
				ram_re    = 1'b1;
				ram_raddr = p_q;
			end
			S_G_RD, S_F_RD: begin
				ram_re    = 1'b1;
				ram_raddr = bp_q;
			end
			S_G_WR: begin
				ram_we    = 1'b1;
				ram_waddr = bp_q;
				ram_wdata = {rd_link, bsize_q};
			end
			S_R_WALK: begin
				if (r_stop || !rwalk_end) begin
					ram_re    = 1'b1;
					ram_raddr = rd_link;
				end
			end
			S_R_NX: begin
				ram_we    = 1'b1;
				ram_waddr = bp_q;
				ram_wdata = {bnew_link, bnew_size};
			end
			S_R_WP: begin
				ram_we    = 1'b1;
				ram_waddr = p_q;
				ram_wdata = {pnew_link, pnew_size};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rover_q      <= '0;
			ready_q      <= 1'b0;
			brk_q        <= BW'(1);
			from_alloc_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q        <= s_tuser[0];
						n_q          <= n_in;
						bp_q         <= baddr_m1[AW-1:0];
						steps_q      <= '0;
						from_alloc_q <= 1'b0;
						if (s_tuser[0] == REQ_FREE && s_tdata[27:16] == '0) begin
							res_addr_q <= '0;
							res_fail_q <= STAT_DONE;
							state_q    <= S_DONE;
						end else if (!ready_q) begin
							state_q <= S_ENS;
						end else if (s_tuser[0] == REQ_ALLOC) begin
							state_q <= S_A_ROV;
						end else begin
							state_q <= S_F_RD;
						end
					end
				end
				S_ENS: begin
					rover_q <= '0;
					ready_q <= 1'b1;
					state_q <= (req_q == REQ_ALLOC) ? S_A_ROV : S_F_RD;
				end
				S_A_ROV: begin
					prev_q  <= rover_q;
					state_q <= S_A_PREV;
				end
				S_A_PREV: begin
					prev_size_q <= rd_size;
					p_q         <= rd_link;
					state_q     <= S_A_WALK;
				end
				S_A_WALK: begin
					if (fit) begin
						rover_q <= prev_q;
						if (exact) begin
							res_addr_q <= PAY_W'(p_plus1);
							res_fail_q <= STAT_DONE;
							state_q    <= S_DONE;
						end else begin
							sp_q    <= split_sum[AW-1:0];
							state_q <= S_A_SPLIT;
						end
					end else if (at_rover) begin
						if (gfail) begin
							res_addr_q <= '0;
							res_fail_q <= STAT_FAIL;
							state_q    <= S_DONE;
						end else begin
							brk_q   <= BW'(gsum);
							bp_q    <= brk_q[AW-1:0];
							bsize_q <= SW'(nu);
							state_q <= S_G_RD;
						end
					end else if (walk_end) begin
						res_addr_q <= '0;
						res_fail_q <= STAT_FAIL;
						state_q    <= S_DONE;
					end else begin
						steps_q     <= steps_q + TW'(1);
						prev_q      <= p_q;
						prev_size_q <= rd_size;
						p_q         <= rd_link;
					end
				end
				S_A_SPLIT: begin
					res_addr_q <= PAY_W'(sp_plus1);
					res_fail_q <= STAT_DONE;
					state_q    <= S_DONE;
				end
				S_A_RDP: begin
					state_q <= S_A_WALK;
				end
				S_G_RD: begin
					state_q <= S_G_WR;
				end
				S_G_WR: begin
					from_alloc_q <= 1'b1;
					state_q      <= S_R_START;
				end
				S_F_RD: begin
					state_q <= S_F_BP;
				end
				S_F_BP: begin
					bsize_q  <= rd_size;
					p_q      <= rover_q;
					rsteps_q <= '0;
					state_q  <= S_R_WALK;
				end
				S_R_START: begin
					p_q      <= rover_q;
					rsteps_q <= '0;
					state_q  <= S_R_WALK;
				end
				S_R_WALK: begin
					if (r_stop) begin
						psize_q <= rd_size;
						nx_q    <= rd_link;
						state_q <= S_R_NX;
					end else if (rwalk_end) begin
						// runaway on a corrupted list
						res_addr_q <= '0;
						res_fail_q <= from_alloc_q ? STAT_FAIL : STAT_DONE;
						state_q    <= S_DONE;
					end else begin
						rsteps_q <= rsteps_q + TW'(1);
						p_q      <= rd_link;
					end
				end
				S_R_NX: begin
					blink_q <= bnew_link;
					bsize_q <= bnew_size;
					state_q <= S_R_WP;
				end
				S_R_WP: begin
					rover_q <= p_q;
					if (!from_alloc_q) begin
						res_addr_q <= '0;
						res_fail_q <= STAT_DONE;
						state_q    <= S_DONE;
					end else if (walk_end) begin
						res_addr_q <= '0;
						res_fail_q <= STAT_FAIL;
						state_q    <= S_DONE;
					end else begin
						// resume the allocate walk past the new rover
						steps_q     <= steps_q + TW'(1);
						prev_q      <= p_q;
						prev_size_q <= pnew_size;
						p_q         <= pnew_link;
						state_q     <= S_A_RDP;
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
				out_addr_q  <= res_addr_q;
				out_fail_q  <= res_fail_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = 16'(out_addr_q);
	assign m_tuser  = out_fail_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mg_q <= MG_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_GROW) begin
			mg_q <= pwdata[MG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_GROW) ? 32'(mg_q) : 32'd0;

	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= BW'(HEAP_UNITS))
		else $error("break point beyond arena");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == STAT_DONE || m_tdata == 16'd0))
		else $error("failed allocation carries an address");

	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("header RAM read and write in one cycle");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |=> ready_q)
		else $error("free list setup lost");

endmodule
